FILE: src/cbbc_pkg.sv
// shared types, character codes and lexing functions for the bracket balance checker
// no dependencies; imported by every module of the block
package cbbc_pkg;

    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_LSQUARE   = 8'h5B;
    localparam logic [7:0] CH_LCURLY    = 8'h7B;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_RSQUARE   = 8'h5D;
    localparam logic [7:0] CH_RCURLY    = 8'h7D;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;

    typedef enum logic [1:0] {
        KIND_PAREN,
        KIND_SQUARE,
        KIND_CURLY
    } kind_t;

    typedef enum logic [1:0] {
        VERDICT_BALANCED,
        VERDICT_UNMATCHED,
        VERDICT_UNCLOSED,
        VERDICT_OVERFLOW
    } verdict_t;

    typedef enum logic [1:0] {
        LEX_CODE,
        LEX_BLOCK,
        LEX_LINE,
        LEX_STRING
    } lex_region_t;

    typedef struct packed {
        lex_region_t region;
        logic        in_char;
    } lex_mode_t;

    localparam lex_mode_t LEX_RESET = '{region: LEX_CODE, in_char: 1'b0};

    typedef struct packed {
        lex_mode_t mode;
        logic      pass;
    } lex_result_t;

    typedef struct packed {
        logic       valid;
        logic       pass;
        logic       last;
        logic [7:0] data;
    } event_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stack_op_t;

    typedef struct packed {
        logic  is_open;
        logic  is_close;
        kind_t kind;
    } bracket_class_t;

    function automatic bracket_class_t classify(input logic [7:0] c);
        bracket_class_t r;
        r = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_PAREN};
        unique case (c)
            CH_LPAREN: begin
                r.is_open = 1'b1;
                r.kind    = KIND_PAREN;
            end
            CH_LSQUARE: begin
                r.is_open = 1'b1;
                r.kind    = KIND_SQUARE;
            end
            CH_LCURLY: begin
                r.is_open = 1'b1;
                r.kind    = KIND_CURLY;
            end
            CH_RPAREN: begin
                r.is_close = 1'b1;
                r.kind     = KIND_PAREN;
            end
            CH_RSQUARE: begin
                r.is_close = 1'b1;
                r.kind     = KIND_SQUARE;
            end
            CH_RCURLY: begin
                r.is_close = 1'b1;
                r.kind     = KIND_CURLY;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic logic [7:0] open_char(input kind_t k);
        logic [7:0] c;
        unique case (k)
            KIND_SQUARE: c = CH_LSQUARE;
            KIND_CURLY:  c = CH_LCURLY;
            default:     c = CH_LPAREN;
        endcase
        return c;
    endfunction

    // one byte judged with its raw predecessor and successor
    function automatic lex_result_t lex_step(
        input lex_mode_t  m,
        input logic [7:0] cur,
        input logic [7:0] prev_byte,
        input logic [7:0] succ,
        input logic       has_succ
    );
        lex_result_t r;
        logic        sq;
        logic        blk;
        logic        lin;
        logic        dq;
        logic        any;
        sq     = m.in_char;
        blk    = (m.region == LEX_BLOCK);
        lin    = (m.region == LEX_LINE);
        dq     = (m.region == LEX_STRING);
        any    = sq | blk | lin | dq;
        r.pass = 1'b0;
        if (!lin && !dq && !blk && cur == CH_SLASH && has_succ && succ == CH_STAR) begin
            blk = 1'b1;
        end else if (!blk && !dq && !lin && cur == CH_SLASH && has_succ
                     && succ == CH_SLASH) begin
            lin = 1'b1;
        end else if (!any && cur == CH_DQUOTE) begin
            dq = 1'b1;
        end else if (!any && cur == CH_SQUOTE) begin
            sq = 1'b1;
        end else begin
            r.pass = !any || cur == CH_NEWLINE;
            if (blk && prev_byte == CH_STAR && cur == CH_SLASH) begin
                blk = 1'b0;
            end
            if (lin && cur == CH_NEWLINE) begin
                lin = 1'b0;
            end
            if (dq && cur == CH_DQUOTE && prev_byte != CH_BACKSLASH) begin
                dq = 1'b0;
            end
            if (sq && cur == CH_SQUOTE && !(has_succ && succ == CH_SQUOTE)) begin
                sq = 1'b0;
            end
        end
        if (blk) begin
            r.mode.region = LEX_BLOCK;
        end else if (lin) begin
            r.mode.region = LEX_LINE;
        end else if (dq) begin
            r.mode.region = LEX_STRING;
        end else begin
            r.mode.region = LEX_CODE;
        end
        r.mode.in_char = sq;
        return r;
    endfunction

endpackage

FILE: src/cbbc_lexer.sv
// lookahead and comment/literal stripping stage, one byte event per cycle while advance is high
// depends on cbbc_pkg for the lexing function and the event type
module cbbc_lexer (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            accept,
    input  logic [7:0]      text_byte,
    input  logic            end_of_text,
    input  logic            advance,
    output cbbc_pkg::event_t ev,
    output logic            tail_busy
);
    import cbbc_pkg::*;

    logic [7:0]  held_reg, held_next;
    logic        held_valid_reg, held_valid_next;
    logic [7:0]  before_reg, before_next;
    lex_mode_t   mode_reg, mode_next;
    event_t      ev_reg, ev_next;
    event_t      tail_reg, tail_next;

    lex_result_t first_res;
    lex_result_t final_res;
    lex_mode_t   mode_mid;
    logic [7:0]  prev_mid;

    always_comb begin
        first_res       = lex_step(mode_reg, held_reg, before_reg, text_byte, 1'b1);
        mode_mid        = held_valid_reg ? first_res.mode : mode_reg;
        prev_mid        = held_valid_reg ? held_reg : before_reg;
        final_res       = lex_step(mode_mid, text_byte, prev_mid, 8'h00, 1'b0);
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        before_next     = before_reg;
        mode_next       = mode_reg;
        ev_next         = ev_reg;
        tail_next       = tail_reg;
        if (advance) begin
            ev_next = '0;
            if (tail_reg.valid) begin
                ev_next   = tail_reg;
                tail_next = '0;
            end else if (accept) begin
                tail_next = '0;
                if (held_valid_reg) begin
                    ev_next = '{valid: first_res.pass, pass: first_res.pass,
                                last: 1'b0, data: held_reg};
                    if (end_of_text) begin
                        tail_next = '{valid: 1'b1, pass: final_res.pass,
                                      last: 1'b1, data: text_byte};
                    end
                end else if (end_of_text) begin
                    ev_next = '{valid: 1'b1, pass: final_res.pass,
                                last: 1'b1, data: text_byte};
                end
                if (end_of_text) begin
                    held_next       = 8'h00;
                    held_valid_next = 1'b0;
                    before_next     = 8'h00;
                    mode_next       = LEX_RESET;
                end else begin
                    held_next       = text_byte;
                    held_valid_next = 1'b1;
                    before_next     = prev_mid;
                    mode_next       = mode_mid;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg       <= 8'h00;
            held_valid_reg <= 1'b0;
            before_reg     <= 8'h00;
            mode_reg       <= LEX_RESET;
            ev_reg         <= '0;
            tail_reg       <= '0;
        end else begin
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            before_reg     <= before_next;
            mode_reg       <= mode_next;
            ev_reg         <= ev_next;
            tail_reg       <= tail_next;
        end
    end

    assign ev        = ev_reg;
    assign tail_busy = tail_reg.valid;

endmodule

FILE: src/cbbc_cell.sv
// one entry of the bracket stack, shifting towards or away from the top
// depends on cbbc_pkg for the bracket kind and stack operation types
module cbbc_cell (
    input  logic                aclk,
    input  cbbc_pkg::stack_op_t op,
    input  cbbc_pkg::kind_t     from_above,
    input  cbbc_pkg::kind_t     from_below,
    output cbbc_pkg::kind_t     kind
);
    import cbbc_pkg::*;

    kind_t kind_reg, kind_next;

    always_comb begin
        kind_next = kind_reg;
        if (op.push) begin
            kind_next = from_above;
        end else if (op.pop) begin
            kind_next = from_below;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
    end

    assign kind = kind_reg;

endmodule

FILE: src/cbbc_tracker.sv
// bracket checking stage: line counter, error latch, depth and the chain of stack cells
// depends on cbbc_pkg and cbbc_cell
module cbbc_tracker #(
    parameter int STACK_DEPTH = 256,
    parameter int LINE_BITS   = 20
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cbbc_pkg::event_t     ev,
    input  logic                 take,
    output logic                 res_valid,
    output logic [1:0]           res_verdict,
    output logic [LINE_BITS-1:0] res_line,
    output logic [7:0]           res_bracket
);
    import cbbc_pkg::*;

    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam logic [DEPTH_W-1:0]   DEPTH_FULL = DEPTH_W'(STACK_DEPTH);
    localparam logic [LINE_BITS-1:0] LINE_TOP   = {LINE_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0] LINE_FIRST = LINE_BITS'(1);

    logic [DEPTH_W-1:0]   depth_reg, depth_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    verdict_t             status_reg, status_next;
    logic [LINE_BITS-1:0] where_reg, where_next;
    logic [7:0]           bracket_reg, bracket_next;

    kind_t          cell_kind [STACK_DEPTH];
    bracket_class_t cls;
    stack_op_t      op;
    logic           check;
    kind_t          next_top;

    always_comb begin
        cls          = classify(ev.data);
        check        = take && ev.valid && ev.pass && status_reg == VERDICT_BALANCED;
        res_valid    = take && ev.valid && ev.last;
        op           = '0;
        depth_next   = depth_reg;
        line_next    = line_reg;
        status_next  = status_reg;
        where_next   = where_reg;
        bracket_next = bracket_reg;
        if (check) begin
            if (cls.is_open) begin
                if (depth_reg >= DEPTH_FULL) begin
                    status_next  = VERDICT_OVERFLOW;
                    where_next   = line_reg;
                    bracket_next = ev.data;
                end else begin
                    op.push    = 1'b1;
                    depth_next = depth_reg + DEPTH_W'(1);
                end
            end else if (cls.is_close) begin
                if (depth_reg == '0 || cell_kind[0] != cls.kind) begin
                    status_next  = VERDICT_UNMATCHED;
                    where_next   = line_reg;
                    bracket_next = ev.data;
                end else begin
                    op.pop     = 1'b1;
                    depth_next = depth_reg - DEPTH_W'(1);
                end
            end else if (ev.data == CH_NEWLINE && line_reg != LINE_TOP) begin
                line_next = line_reg + LINE_BITS'(1);
            end
        end

        if (op.push) begin
            next_top = cls.kind;
        end else if (op.pop) begin
            next_top = cell_kind[1];
        end else begin
            next_top = cell_kind[0];
        end

        if (status_next != VERDICT_BALANCED) begin
            res_verdict = status_next;
            res_line    = where_next;
            res_bracket = bracket_next;
        end else if (depth_next != '0) begin
            res_verdict = VERDICT_UNCLOSED;
            res_line    = line_next;
            res_bracket = open_char(next_top);
        end else begin
            res_verdict = VERDICT_BALANCED;
            res_line    = '0;
            res_bracket = 8'h00;
        end

        // end of text: back to the state of a fresh text
        if (res_valid) begin
            depth_next   = '0;
            line_next    = LINE_FIRST;
            status_next  = VERDICT_BALANCED;
            where_next   = '0;
            bracket_next = 8'h00;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg   <= '0;
            line_reg    <= LINE_FIRST;
            status_reg  <= VERDICT_BALANCED;
            where_reg   <= '0;
            bracket_reg <= 8'h00;
        end else begin
            depth_reg   <= depth_next;
            line_reg    <= line_next;
            status_reg  <= status_next;
            where_reg   <= where_next;
            bracket_reg <= bracket_next;
        end
    end

    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        kind_t above;
        kind_t below;
        if (i == 0) begin : g_top
            assign above = cls.kind;
        end else begin : g_inner
            assign above = cell_kind[i-1];
        end
        if (i == STACK_DEPTH - 1) begin : g_bottom
            assign below = cell_kind[i];
        end else begin : g_upper
            assign below = cell_kind[i+1];
        end
        cbbc_cell u_cell (
            .aclk       (aclk),
            .op         (op),
            .from_above (above),
            .from_below (below),
            .kind       (cell_kind[i])
        );
    end

endmodule

FILE: src/c_source_bracket_balance_checker.sv
// top level of the C source bracket balance checker
// depends on cbbc_pkg, cbbc_lexer and cbbc_tracker
//
// Usage: s_ beats carry one source byte each, s_end_of_text marks the last byte of a text.
// Comments, string and character literals are stripped, newlines are counted, and (), []
// and {} are checked on a stack held in a row of shifting cells, the top always in the
// first cell. One m_ beat per text gives the verdict, the line of the first error and
// the bracket involved; a balanced text reports zero line and zero bracket.
// Throughput: one beat per cycle while s_ready is high. After the last beat of a text of
// two or more bytes the input pauses, as the held-back byte and the last byte each take
// a slot of the one-byte-per-cycle stack stage.
// Result path: the last byte is registered in the lookahead stage, checked in the stack
// stage, and its verdict is registered in the output register that drives m_valid.
// Reset: synchronous, active low; all control state returns to the start of a text and
// m_valid drops. Stack contents are not cleared, only the depth.
// Stall: the result waits in the output register while the next text streams in; only
// when a second verdict is due before the first is taken does s_ready drop and the
// pipeline hold.
module c_source_bracket_balance_checker #(
    parameter int STACK_DEPTH = 256,
    parameter int LINE_BITS   = 20
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_text_byte,
    input  logic                 s_end_of_text,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_verdict,
    output logic [LINE_BITS-1:0] m_error_line,
    output logic [7:0]           m_bracket_byte
);
    import cbbc_pkg::*;

    event_t               ev;
    logic                 tail_busy;
    logic                 stall;
    logic                 advance;
    logic                 accept;
    logic                 res_valid;
    logic [1:0]           res_verdict;
    logic [LINE_BITS-1:0] res_line;
    logic [7:0]           res_bracket;

    logic                 m_valid_reg, m_valid_next;
    logic [1:0]           verdict_reg, verdict_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic [7:0]           bracket_reg, bracket_next;

    assign stall   = ev.valid && ev.last && m_valid_reg && !m_ready;
    assign advance = !stall;
    assign s_ready = advance && !tail_busy;
    assign accept  = s_valid && s_ready;

    cbbc_lexer u_lexer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .text_byte   (s_text_byte),
        .end_of_text (s_end_of_text),
        .advance     (advance),
        .ev          (ev),
        .tail_busy   (tail_busy)
    );

    cbbc_tracker #(
        .STACK_DEPTH (STACK_DEPTH),
        .LINE_BITS   (LINE_BITS)
    ) u_tracker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ev          (ev),
        .take        (advance),
        .res_valid   (res_valid),
        .res_verdict (res_verdict),
        .res_line    (res_line),
        .res_bracket (res_bracket)
    );

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        verdict_next = verdict_reg;
        line_next    = line_reg;
        bracket_next = bracket_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
            verdict_next = res_verdict;
            line_next    = res_line;
            bracket_next = res_bracket;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        verdict_reg <= verdict_next;
        line_reg    <= line_next;
        bracket_reg <= bracket_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_verdict      = verdict_reg;
    assign m_error_line   = line_reg;
    assign m_bracket_byte = bracket_reg;

endmodule

FILE: src/cbbc_checker.sv
// port-level assertions for the bracket balance checker, bound to the top level
// depends on cbbc_pkg and c_source_bracket_balance_checker
module cbbc_checker #(
    parameter int LINE_BITS = 20
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic [7:0]           s_text_byte,
    input logic                 s_end_of_text,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [1:0]           m_verdict,
    input logic [LINE_BITS-1:0] m_error_line,
    input logic [7:0]           m_bracket_byte
);
    import cbbc_pkg::*;

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat shown straight after reset");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_verdict)
            && $stable(m_error_line) && $stable(m_bracket_byte))
        else $error("stalled result beat changed");

    a_balanced_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_verdict == VERDICT_BALANCED |->
            m_error_line == '0 && m_bracket_byte == 8'h00)
        else $error("balanced verdict with line or bracket set");

    a_error_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_verdict != VERDICT_BALANCED |-> m_error_line != '0
            && ((m_verdict == VERDICT_UNMATCHED)
                ? (m_bracket_byte == CH_RPAREN || m_bracket_byte == CH_RSQUARE
                   || m_bracket_byte == CH_RCURLY)
                : (m_bracket_byte == CH_LPAREN || m_bracket_byte == CH_LSQUARE
                   || m_bracket_byte == CH_LCURLY)))
        else $error("error verdict without a line or a matching bracket");

    a_beat_known: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> !$isunknown({s_text_byte, s_end_of_text}))
        else $error("input beat taken with unknown payload");

endmodule

bind c_source_bracket_balance_checker cbbc_checker #(.LINE_BITS(LINE_BITS)) u_cbbc_checker (.*);

FILE: verif/c_source_bracket_balance_checker_test.sv
`timescale 1ns / 1ps
// self-checking testbench for c_source_bracket_balance_checker: a table of texts, then random
// texts, with random gaps and stalls; every verdict beat is checked against the table or a predictor
// depends on cbbc_pkg and c_source_bracket_balance_checker
module c_source_bracket_balance_checker_test;
    import cbbc_pkg::*;

    localparam int                   LINE_BITS    = 20;
    localparam int                   NEST_MAX     = 256;
    localparam logic [LINE_BITS-1:0] LINE_TOP     = '1;
    localparam int                   HOLD_CYCLES  = 300;
    localparam int                   DRAIN_CYCLES = 10;
    localparam int unsigned          CYCLE_LIMIT  = 100_000;

    typedef struct {
        verdict_t             verdict;
        logic [LINE_BITS-1:0] line;
        logic [7:0]           bracket;
    } verdict_rec_t;

    typedef struct {
        bit           typed;
        verdict_rec_t rec;
    } text_plan_t;

    typedef struct {
        int         lead;
        string      body;
        int         reps;
        string      tail;
        text_plan_t plan;
    } script_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [7:0]           s_text_byte;
    logic                 s_end_of_text;
    logic                 m_valid;
    logic                 m_ready;
    logic [1:0]           m_verdict;
    logic [LINE_BITS-1:0] m_error_line;
    logic [7:0]           m_bracket_byte;

    // predictor state
    kind_t                nest_kind [NEST_MAX];
    int                   nest_depth;
    logic [LINE_BITS-1:0] line_no;
    lex_region_t          region;
    bit                   in_char_lit;
    logic [7:0]           held_char;
    bit                   held_ok;
    logic [7:0]           prior_char;
    verdict_t             first_fault;
    logic [LINE_BITS-1:0] fault_line;
    logic [7:0]           fault_char;

    verdict_rec_t         verdicts_due [$];
    text_plan_t           text_plans [$];
    script_row_t          script [$];
    logic [7:0]           text_buf [$];
    verdict_rec_t         due;
    int                   faults;
    int                   bytes_sent;
    int unsigned          cycles;
    bit                   idle_en;
    bit                   hold_req;

    c_source_bracket_balance_checker #(
        .STACK_DEPTH (NEST_MAX),
        .LINE_BITS   (LINE_BITS)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_text_byte    (s_text_byte),
        .s_end_of_text  (s_end_of_text),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_verdict      (m_verdict),
        .m_error_line   (m_error_line),
        .m_bracket_byte (m_bracket_byte)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    function automatic logic [7:0] bracket_char(kind_t k, bit closing);
        case (k)
            KIND_SQUARE: return closing ? CH_RSQUARE : CH_LSQUARE;
            KIND_CURLY:  return closing ? CH_RCURLY : CH_LCURLY;
            default:     return closing ? CH_RPAREN : CH_LPAREN;
        endcase
    endfunction

    function automatic kind_t kind_of_char(logic [7:0] c);
        case (c)
            CH_LSQUARE, CH_RSQUARE: return KIND_SQUARE;
            CH_LCURLY, CH_RCURLY:   return KIND_CURLY;
            default:                return KIND_PAREN;
        endcase
    endfunction

    function automatic void restart_text();
        nest_depth  = 0;
        line_no     = LINE_BITS'(1);
        region      = LEX_CODE;
        in_char_lit = 1'b0;
        held_char   = 8'h00;
        held_ok     = 1'b0;
        prior_char  = 8'h00;
        first_fault = VERDICT_BALANCED;
        fault_line  = '0;
        fault_char  = 8'h00;
    endfunction

    function automatic void note_fault(verdict_t v, logic [7:0] c);
        first_fault = v;
        fault_line  = line_no;
        fault_char  = c;
    endfunction

    function automatic void scan_char(logic [7:0] cur, logic [7:0] prev, logic [7:0] nxt,
                                      bit has_nxt);
        bit sq;
        bit blk;
        bit lin;
        bit dq;
        bit busy;
        sq   = in_char_lit;
        blk  = (region == LEX_BLOCK);
        lin  = (region == LEX_LINE);
        dq   = (region == LEX_STRING);
        busy = sq || blk || lin || dq;
        if (!blk && !lin && !dq && cur == CH_SLASH && has_nxt && nxt == CH_STAR) begin
            blk = 1'b1;
        end else if (!blk && !lin && !dq && cur == CH_SLASH && has_nxt && nxt == CH_SLASH) begin
            lin = 1'b1;
        end else if (!busy && cur == CH_DQUOTE) begin
            dq = 1'b1;
        end else if (!busy && cur == CH_SQUOTE) begin
            sq = 1'b1;
        end else begin
            if ((!busy || cur == CH_NEWLINE) && first_fault == VERDICT_BALANCED) begin
                case (cur)
                    CH_LPAREN, CH_LSQUARE, CH_LCURLY: begin
                        if (nest_depth >= NEST_MAX) begin
                            note_fault(VERDICT_OVERFLOW, cur);
                        end else begin
                            nest_kind[nest_depth] = kind_of_char(cur);
                            nest_depth++;
                        end
                    end
                    CH_RPAREN, CH_RSQUARE, CH_RCURLY: begin
                        if (nest_depth == 0 || nest_kind[nest_depth-1] != kind_of_char(cur)) begin
                            note_fault(VERDICT_UNMATCHED, cur);
                        end else begin
                            nest_depth--;
                        end
                    end
                    CH_NEWLINE: begin
                        if (line_no != LINE_TOP) begin
                            line_no++;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (blk && prev == CH_STAR && cur == CH_SLASH) begin
                blk = 1'b0;
            end
            if (lin && cur == CH_NEWLINE) begin
                lin = 1'b0;
            end
            if (dq && cur == CH_DQUOTE && prev != CH_BACKSLASH) begin
                dq = 1'b0;
            end
            if (sq && cur == CH_SQUOTE && !(has_nxt && nxt == CH_SQUOTE)) begin
                sq = 1'b0;
            end
        end
        if (blk) begin
            region = LEX_BLOCK;
        end else if (lin) begin
            region = LEX_LINE;
        end else if (dq) begin
            region = LEX_STRING;
        end else begin
            region = LEX_CODE;
        end
        in_char_lit = sq;
    endfunction

    function automatic void take_byte(logic [7:0] b, bit last);
        verdict_rec_t rec;
        text_plan_t   plan;
        if (held_ok) begin
            scan_char(held_char, prior_char, b, 1'b1);
            prior_char = held_char;
        end
        held_char = b;
        held_ok   = 1'b1;
        if (last) begin
            scan_char(b, prior_char, 8'h00, 1'b0);
            if (first_fault != VERDICT_BALANCED) begin
                rec = '{first_fault, fault_line, fault_char};
            end else if (nest_depth > 0) begin
                rec = '{VERDICT_UNCLOSED, line_no, bracket_char(nest_kind[nest_depth-1], 1'b0)};
            end else begin
                rec = '{VERDICT_BALANCED, '0, 8'h00};
            end
            if (text_plans.size() != 0) begin
                plan = text_plans.pop_front();
                if (plan.typed) begin
                    rec = plan.rec;
                end
            end
            verdicts_due.push_back(rec);
            restart_text();
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                take_byte(s_text_byte, s_end_of_text);
            end
            if (m_valid && m_ready) begin
                if (verdicts_due.size() == 0) begin
                    $error("verdict beat with no text pending");
                    faults++;
                end else begin
                    due = verdicts_due.pop_front();
                    if (m_verdict !== due.verdict) begin
                        $error("verdict: expected %0d, got %0d", due.verdict, m_verdict);
                        faults++;
                    end
                    if (m_error_line !== due.line) begin
                        $error("error_line: expected %0d, got %0d", due.line, m_error_line);
                        faults++;
                    end
                    if (m_bracket_byte !== due.bracket) begin
                        $error("bracket_byte: expected %02h, got %02h", due.bracket,
                               m_bracket_byte);
                        faults++;
                    end
                end
            end
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                m_ready <= idle_en ? ($urandom_range(99) >= 34) : 1'b1;
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_byte(logic [7:0] b, bit last);
        while (idle_en && $urandom_range(99) < 34) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_text_byte   <= b;
        s_end_of_text <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
        @(negedge aclk);
    endtask

    function automatic void add_row(int lead, string body, int reps, string tail, bit typed,
                                    verdict_t v, logic [LINE_BITS-1:0] line, logic [7:0] br);
        script_row_t r;
        r.lead      = lead;
        r.body      = body;
        r.reps      = reps;
        r.tail      = tail;
        r.plan.typed = typed;
        r.plan.rec  = '{v, line, br};
        script.push_back(r);
    endfunction

    function automatic logic [7:0] filler();
        string marks;
        marks = "()[]{}/*\"'\\\n ";
        case ($urandom_range(3))
            0:       return 8'($urandom_range(255));
            1:       return marks[$urandom_range(marks.len() - 1)];
            default: return 8'($urandom_range(8'h61, 8'h7A));
        endcase
    endfunction

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++) begin
            text_buf.push_back(s[i]);
        end
    endfunction

    function automatic void build_text();
        kind_t open_kinds [$];
        kind_t k;
        int    style;
        text_buf.delete();
        style = $urandom_range(99);
        if (style < 4) begin
            repeat ($urandom_range(250, 262)) begin
                text_buf.push_back(bracket_char(kind_t'($urandom_range(2)), 1'b0));
            end
            repeat ($urandom_range(3)) text_buf.push_back(filler());
        end else if (style < 75) begin
            repeat ($urandom_range(1, 24)) begin
                case ($urandom_range(9))
                    0, 1: begin
                        k = kind_t'($urandom_range(2));
                        open_kinds.push_back(k);
                        text_buf.push_back(bracket_char(k, 1'b0));
                    end
                    2, 3: begin
                        if (open_kinds.size() != 0) begin
                            text_buf.push_back(bracket_char(open_kinds.pop_back(), 1'b1));
                        end
                    end
                    4: begin
                        put_str("/*");
                        repeat ($urandom_range(4)) text_buf.push_back(filler());
                        put_str("*/");
                    end
                    5: begin
                        put_str("//");
                        repeat ($urandom_range(4)) text_buf.push_back(filler());
                        put_str("\n");
                    end
                    6: begin
                        put_str("\"");
                        repeat ($urandom_range(3)) begin
                            if ($urandom_range(3) == 0) begin
                                put_str("\\\"");
                            end else begin
                                text_buf.push_back(bracket_char(kind_t'($urandom_range(2)),
                                                                1'($urandom_range(1))));
                            end
                        end
                        put_str("\"");
                    end
                    7: begin
                        put_str("'");
                        text_buf.push_back(bracket_char(kind_t'($urandom_range(2)),
                                                        1'($urandom_range(1))));
                        put_str("'");
                    end
                    8: put_str("\n");
                    default: text_buf.push_back(filler());
                endcase
            end
            if ($urandom_range(4) != 0) begin
                while (open_kinds.size() != 0) begin
                    text_buf.push_back(bracket_char(open_kinds.pop_back(), 1'b1));
                end
            end
            if (text_buf.size() != 0 && $urandom_range(9) == 0) begin
                text_buf[$urandom_range(text_buf.size() - 1)] = filler();
            end
        end else begin
            repeat ($urandom_range(1, 16)) text_buf.push_back(filler());
        end
        if (text_buf.size() == 0) begin
            text_buf.push_back(filler());
        end
    endfunction

    initial begin
        text_plan_t plan;
        int         total;
        int         k;
        int         rnd_texts;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_text_byte   = 8'h00;
        s_end_of_text = 1'b0;
        idle_en       = 1'b1;
        hold_req      = 1'b0;
        faults        = 0;
        bytes_sent    = 0;
        restart_text();

        //      lead body                     reps     tail typed verdict        line  bracket
        add_row(-1, "x",                      1,       "",  1, VERDICT_BALANCED,  0, 8'h00);
        add_row(-1, "(",                      1,       "",  1, VERDICT_UNCLOSED,  1, CH_LPAREN);
        add_row(-1, ")",                      1,       "",  1, VERDICT_UNMATCHED, 1, CH_RPAREN);
        add_row(-1, "([{}])",                 1,       "",  1, VERDICT_BALANCED,  0, 8'h00);
        add_row(-1, "(]",                     1,       "",  1, VERDICT_UNMATCHED, 1, CH_RSQUARE);
        add_row(-1, "{\n\n",                  1,       "",  1, VERDICT_UNCLOSED,  3, CH_LCURLY);
        add_row(-1, ")(((",                   1,       "",  1, VERDICT_UNMATCHED, 1, CH_RPAREN);
        add_row(-1, "/*(*/)",                 1,       "",  0, VERDICT_BALANCED,  0, 8'h00);
        add_row(-1, "/*/)",                   1,       "",  0, VERDICT_BALANCED,  0, 8'h00);
        add_row(-1, "// (\n)",                1,       "",  0, VERDICT_BALANCED,  0, 8'h00);
        add_row(-1, "\"(\\\")\"(",            1,       "",  0, VERDICT_BALANCED,  0, 8'h00);
        add_row(-1, "'('",                    1,       "",  0, VERDICT_BALANCED,  0, 8'h00);
        add_row(-1, "'/*'x*/(",               1,       "",  0, VERDICT_BALANCED,  0, 8'h00);
        add_row(-1, "''')",                   1,       "",  0, VERDICT_BALANCED,  0, 8'h00);
        add_row(-1, "'x'",                    1,       "",  0, VERDICT_BALANCED,  0, 8'h00);
        add_row(-1, "(/",                     1,       "",  0, VERDICT_BALANCED,  0, 8'h00);
        add_row(0,  "\377]",                  1,       "",  0, VERDICT_BALANCED,  0, 8'h00);
        add_row(-1, "\"//(\"\n/*\"*/{",       1,       "",  0, VERDICT_BALANCED,  0, 8'h00);
        add_row(-1, "(",                      256,     "",  1, VERDICT_UNCLOSED,  1, CH_LPAREN);
        add_row(-1, "[",                      257,     "",  1, VERDICT_OVERFLOW,  1, CH_LSQUARE);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (script[r]) begin
            text_plans.push_back(script[r].plan);
            // the long nesting runs go without gaps or stalls
            idle_en = script[r].reps < 200;
            total   = (script[r].lead >= 0) + script[r].reps * script[r].body.len()
                      + script[r].tail.len();
            k       = 0;
            if (script[r].lead >= 0) begin
                k++;
                send_byte(8'(script[r].lead), k == total);
            end
            repeat (script[r].reps) begin
                for (int i = 0; i < script[r].body.len(); i++) begin
                    k++;
                    send_byte(script[r].body[i], k == total);
                end
            end
            for (int i = 0; i < script[r].tail.len(); i++) begin
                k++;
                send_byte(script[r].tail[i], k == total);
            end
        end

        idle_en    = 1'b1;
        rnd_texts  = 0;
        plan.typed = 1'b0;
        while (bytes_sent < 1000 || rnd_texts < 12) begin
            build_text();
            text_plans.push_back(plan);
            if (rnd_texts == 4) begin
                hold_req = 1'b1;
            end
            foreach (text_buf[i]) begin
                send_byte(text_buf[i], i == text_buf.size() - 1);
            end
            rnd_texts++;
        end
        s_valid <= 1'b0;

        while (verdicts_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (faults == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
